// ===== design/rpxy_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpxy_pkg
// Constants, stage types and the elaborated sine/cosine table for the radar
// sample polar to cartesian converter.
// ----------------------------------------------------------------------------
package rpxy_pkg;

   localparam int MAX_SAMPLES  = 4096;
   localparam int LAST_W       = $clog2(MAX_SAMPLES);
   localparam int FULL_TURN    = 5760;
   localparam int QUARTER_TURN = 1440;
   localparam int EIGHTH_TURN  = 720;
   localparam int ROM_DEPTH    = EIGHTH_TURN + 1;
   localparam int ROM_AW       = $clog2(ROM_DEPTH);
   localparam int TRIG_W       = 16;
   localparam int NUM_W        = 20 + LAST_W;
   localparam int REM_W        = NUM_W + TRIG_W;
   localparam int Q_W          = 21;
   localparam int DIV_STAGES   = Q_W;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // csr register indexes
   localparam logic CSR_MIN_INTENSITY = 1'b0;
   localparam logic CSR_ANGLE_OFFSET  = 1'b1;

   // quadrant codes
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   typedef logic [2*TRIG_W-1:0] trig_rom_type [0:ROM_DEPTH-1];

   typedef struct packed {
      logic [12:0]       ang;
      logic [19:0]       range;
      logic [LAST_W-1:0] idx;
      logic [LAST_W-1:0] last;
      logic              zero;
      logic [7:0]        inten;
   } s1_type;

   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [1:0]        quad;
      logic              swap;
      logic [LAST_W-1:0] last;
      logic              zero;
      logic [7:0]        inten;
   } s2_type;

   typedef struct packed {
      logic [REM_W-1:0]  px;
      logic [REM_W-1:0]  py;
      logic              negx;
      logic              negy;
      logic [LAST_W-1:0] last;
      logic              zero;
      logic [7:0]        inten;
   } s3_type;

   typedef struct packed {
      logic [REM_W-1:0]  remx;
      logic [REM_W-1:0]  remy;
      logic [Q_W-1:0]    qx;
      logic [Q_W-1:0]    qy;
      logic              negx;
      logic              negy;
      logic [LAST_W-1:0] last;
      logic              zero;
      logic [7:0]        inten;
   } div_type;

   // Q2.30 series on the first octant, rounded to Q1.15
   function automatic logic [TRIG_W-1:0] trig_series(input logic [63:0] x,
                                                     input logic sine);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] prod;
      logic signed [63:0] sum;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = sine ? x : (64'd1 << 30);
      sum = $signed(term);
      for (int k = 0; k < 6; k++) begin
         prod = (term * x2) >> 30;
         if (sine) begin
            case (k)
               0:       term = prod / 64'd6;
               1:       term = prod / 64'd20;
               2:       term = prod / 64'd42;
               3:       term = prod / 64'd72;
               4:       term = prod / 64'd110;
               default: term = prod / 64'd156;
            endcase
         end else begin
            case (k)
               0:       term = prod / 64'd2;
               1:       term = prod / 64'd12;
               2:       term = prod / 64'd30;
               3:       term = prod / 64'd56;
               4:       term = prod / 64'd90;
               default: term = prod / 64'd132;
            endcase
         end
         if (k % 2 == 1) begin
            sum = sum + $signed(term);
         end else begin
            sum = sum - $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      trig_series = TRIG_W'(($unsigned(sum) + 64'd16384) >> 15);
   endfunction

   // entry a holds {sin, cos} of a/16 degree
   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      logic [63:0]  x;
      for (int a = 0; a < ROM_DEPTH; a++) begin
         x = (64'(a) * PI_Q30 + 64'd1440) / 64'd2880;
         rom[a] = {trig_series(x, 1'b1), trig_series(x, 1'b0)};
      end
      build_trig_rom = rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

// ===== design/radar_sample_polar_to_xy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_sample_polar_to_xy
// Pipeline of 26 register stages from the accepting edge to rsp_valid.
// Throughput: one item per cycle; a stalled stage only holds the stages
// behind it, so input is taken while any bubble remains. The 21-stage divider
// sets the latency.
// Items under the intensity threshold are dropped at the input.
// Reset (synchronous) clears valid bits and both registers to zero.
// ----------------------------------------------------------------------------
module radar_sample_polar_to_xy (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [12:0]         req_spoke_angle,
   input  logic [19:0]         req_range_max,
   input  logic [11:0]         req_sample_index,
   input  logic [12:0]         req_samples_in_spoke,
   input  logic [7:0]          req_intensity,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [20:0]  rsp_x_mm,
   output logic signed [20:0]  rsp_y_mm,
   output logic [7:0]          rsp_point_intensity,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [13:0]         csr_data
);
   import rpxy_pkg::*;

   localparam int NSTG = 3 + DIV_STAGES + 2;

   logic [7:0]           min_inten_ff;
   logic signed [13:0]   offset_ff;
   logic [NSTG-1:0]      vld_ff;
   logic [NSTG:0]        en;
   s1_type               s1_ff, s1_in;
   s2_type               s2_ff, s2_in;
   s3_type               s3_ff, s3_in;
   logic [2*TRIG_W-1:0]  rom_ff;
   logic [ROM_AW-1:0]    rom_addr;
   div_type              div_ff [0:DIV_STAGES];
   div_type              div_in [0:DIV_STAGES];
   logic signed [Q_W-1:0] x_ff, y_ff, x_in, y_in;
   logic [7:0]           inten_ff;
   logic                 drop;
   logic signed [15:0]   ang_sum;
   logic [12:0]          cnt_c;
   logic [10:0]          r_ang;
   logic [TRIG_W-1:0]    s0, c0, magx, magy;

   // ---------------- csr ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_inten_ff <= '0;
         offset_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_INTENSITY: min_inten_ff <= csr_data[7:0];
            CSR_ANGLE_OFFSET:  offset_ff    <= $signed(csr_data);
            default:           ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   always_comb begin
      en[NSTG] = !rsp_stall;
      for (int i = NSTG - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_stall = !en[0];
   assign drop      = req_intensity < min_inten_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid && !drop;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: angle wrap, clamps ----------------
   always_comb begin
      ang_sum = $signed({3'b000, req_spoke_angle}) + 16'(offset_ff);
      s1_in = '0;
      if (ang_sum >= 16'sd11520) begin
         s1_in.ang = 13'(ang_sum - 16'sd11520);
      end else if (ang_sum >= 16'sd5760) begin
         s1_in.ang = 13'(ang_sum - 16'sd5760);
      end else if (ang_sum >= 16'sd0) begin
         s1_in.ang = 13'(ang_sum);
      end else if (ang_sum >= -16'sd5760) begin
         s1_in.ang = 13'(ang_sum + 16'sd5760);
      end else begin
         s1_in.ang = 13'(ang_sum + 16'sd11520);
      end
      cnt_c = (req_samples_in_spoke > 13'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES)
                                                         : req_samples_in_spoke;
      s1_in.zero  = cnt_c < 13'd2;
      s1_in.last  = s1_in.zero ? LAST_W'(1) : LAST_W'(cnt_c - 13'd1);
      s1_in.idx   = (LAST_W'(req_sample_index) > s1_in.last) ? s1_in.last
                                                             : LAST_W'(req_sample_index);
      s1_in.range = req_range_max;
      s1_in.inten = req_intensity;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- stage 2: quadrant, table read, range product ----------------
   always_comb begin
      s2_in = '0;
      if (s1_ff.ang < 13'(QUARTER_TURN)) begin
         s2_in.quad = QUAD_I;
         r_ang      = 11'(s1_ff.ang);
      end else if (s1_ff.ang < 13'(2 * QUARTER_TURN)) begin
         s2_in.quad = QUAD_II;
         r_ang      = 11'(s1_ff.ang - 13'(QUARTER_TURN));
      end else if (s1_ff.ang < 13'(3 * QUARTER_TURN)) begin
         s2_in.quad = QUAD_III;
         r_ang      = 11'(s1_ff.ang - 13'(2 * QUARTER_TURN));
      end else begin
         s2_in.quad = QUAD_IV;
         r_ang      = 11'(s1_ff.ang - 13'(3 * QUARTER_TURN));
      end
      s2_in.swap  = r_ang > 11'(EIGHTH_TURN);
      rom_addr    = s2_in.swap ? ROM_AW'(11'(QUARTER_TURN) - r_ang) : ROM_AW'(r_ang);
      s2_in.num   = NUM_W'(s1_ff.range) * NUM_W'(s1_ff.idx);
      s2_in.last  = s1_ff.last;
      s2_in.zero  = s1_ff.zero;
      s2_in.inten = s1_ff.inten;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rom_ff <= TRIG_ROM[rom_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------- stage 3: sign fold, trig products ----------------
   always_comb begin
      s0 = s2_ff.swap ? rom_ff[TRIG_W-1:0] : rom_ff[2*TRIG_W-1:TRIG_W];
      c0 = s2_ff.swap ? rom_ff[2*TRIG_W-1:TRIG_W] : rom_ff[TRIG_W-1:0];
      s3_in = '0;
      case (s2_ff.quad)
         QUAD_I: begin
            magx = s0; s3_in.negx = 1'b0;
            magy = c0; s3_in.negy = 1'b0;
         end
         QUAD_II: begin
            magx = c0; s3_in.negx = 1'b0;
            magy = s0; s3_in.negy = 1'b1;
         end
         QUAD_III: begin
            magx = s0; s3_in.negx = 1'b1;
            magy = c0; s3_in.negy = 1'b1;
         end
         default: begin
            magx = c0; s3_in.negx = 1'b1;
            magy = s0; s3_in.negy = 1'b0;
         end
      endcase
      s3_in.px    = REM_W'(s2_ff.num) * REM_W'(magx);
      s3_in.py    = REM_W'(s2_ff.num) * REM_W'(magy);
      s3_in.last  = s2_ff.last;
      s3_in.zero  = s2_ff.zero;
      s3_in.inten = s2_ff.inten;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- stage 4: rounding bias ----------------
   always_comb begin
      div_in[0]       = '0;
      div_in[0].remx  = s3_ff.px + (REM_W'(s3_ff.last) << 14);
      div_in[0].remy  = s3_ff.py + (REM_W'(s3_ff.last) << 14);
      div_in[0].negx  = s3_ff.negx;
      div_in[0].negy  = s3_ff.negy;
      div_in[0].last  = s3_ff.last;
      div_in[0].zero  = s3_ff.zero;
      div_in[0].inten = s3_ff.inten;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int K = DIV_STAGES - 1 - j;
      logic [REM_W-1:0] dsh;

      always_comb begin
         dsh       = REM_W'(div_ff[j].last) << (15 + K);
         div_in[j+1] = div_ff[j];
         if (div_ff[j].remx >= dsh) begin
            div_in[j+1].remx  = div_ff[j].remx - dsh;
            div_in[j+1].qx[K] = 1'b1;
         end
         if (div_ff[j].remy >= dsh) begin
            div_in[j+1].remy  = div_ff[j].remy - dsh;
            div_in[j+1].qy[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[4+j]) begin
            div_ff[j+1] <= div_in[j+1];
         end
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      x_in = div_ff[DIV_STAGES].negx ? -$signed(div_ff[DIV_STAGES].qx)
                                     : $signed(div_ff[DIV_STAGES].qx);
      y_in = div_ff[DIV_STAGES].negy ? -$signed(div_ff[DIV_STAGES].qy)
                                     : $signed(div_ff[DIV_STAGES].qy);
      if (div_ff[DIV_STAGES].zero) begin
         x_in = '0;
         y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         inten_ff <= div_ff[DIV_STAGES].inten;
      end
   end

   assign rsp_valid           = vld_ff[NSTG-1];
   assign rsp_x_mm            = x_ff;
   assign rsp_y_mm            = y_ff;
   assign rsp_point_intensity = inten_ff;

   // ---------------- assertions ----------------
   a_ang_wrapped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> s1_ff.ang < 13'(FULL_TURN))
      else $error("wrapped angle out of range");

   a_rom_addr: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> rom_addr <= ROM_AW'(EIGHTH_TURN))
      else $error("table address past the octant");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NSTG-2] && !div_ff[DIV_STAGES].zero) |->
         (div_ff[DIV_STAGES].remx < (REM_W'(div_ff[DIV_STAGES].last) << 15)) &&
         (div_ff[DIV_STAGES].remy < (REM_W'(div_ff[DIV_STAGES].last) << 15)))
      else $error("divider remainder not reduced");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> !req_stall)
      else $error("stall with empty first stage");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_x_mm != 21'sh100000) && (rsp_y_mm != 21'sh100000))
      else $error("coordinate outside range");

endmodule
